/* rtl/tcpu_pkg.sv */
// Shared types and codes of the toy processor execute stage.
`timescale 1ns / 1ps
package tcpu_pkg;

    localparam int DATA_W     = 16;
    localparam int REG_NUMBER = 8;

    // instruction kinds
    localparam logic [2:0] ACT_ALU_REG = 3'd0;
    localparam logic [2:0] ACT_ALU_IMM = 3'd1;
    localparam logic [2:0] ACT_JMP_REG = 3'd2;
    localparam logic [2:0] ACT_JMP_IMM = 3'd3;
    localparam logic [2:0] ACT_BRANCH  = 3'd4;

    // ALU operations
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_SHL = 4'd2;
    localparam logic [3:0] OP_SHR = 4'd3;
    localparam logic [3:0] OP_AND = 4'd4;
    localparam logic [3:0] OP_OR  = 4'd5;
    localparam logic [3:0] OP_XOR = 4'd6;
    localparam logic [3:0] OP_MUL = 4'd7;

    // jump conditions
    localparam logic [2:0] CND_ALWAYS   = 3'd0;
    localparam logic [2:0] CND_NEVER    = 3'd1;
    localparam logic [2:0] CND_ZERO     = 3'd2;
    localparam logic [2:0] CND_NONZERO  = 3'd3;
    localparam logic [2:0] CND_CARRY    = 3'd4;
    localparam logic [2:0] CND_NOCARRY  = 3'd5;
    localparam logic [2:0] CND_CARRY_Z  = 3'd6;
    localparam logic [2:0] CND_NEITHER  = 3'd7;

    typedef struct packed {
        logic [2:0]        action;
        logic [3:0]        alu_op;
        logic [2:0]        dest_reg;
        logic [2:0]        left_reg;
        logic [2:0]        right_reg;
        logic [DATA_W-1:0] immediate;
        logic [2:0]        condition;
        logic [2:0]        length;
    } t_instr;

    typedef struct packed {
        logic [DATA_W-1:0] next_pc;
        logic [DATA_W-1:0] alu_value;
        logic              zero_now;
        logic              taken;
        logic              bad_op;
    } t_result;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              bad;
    } t_alu_rsp;

endpackage

/* rtl/tcpu_in_if.sv */
// Request channel carrying one decoded instruction.
`timescale 1ns / 1ps
interface tcpu_in_if;
    logic            valid;
    logic            ready;
    tcpu_pkg::t_instr data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tcpu_out_if.sv */
// Response channel carrying one retired-instruction result.
`timescale 1ns / 1ps
interface tcpu_out_if;
    logic             valid;
    logic             ready;
    tcpu_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/toy_cpu_execute_stage_core.sv */
// Top level of the toy processor execute stage.
//
//  channel  | direction | payload                                   | handshake
//  i_req    | in        | action, alu_op, regs, immediate, cond, len | valid/ready
//  o_rsp    | out       | next_pc, alu_value, zero_now, taken, bad_op | valid/ready
//
// One instruction per cycle while the result side is not stalled. An accepted request
// reads its two source registers into the operand stage (with bypass of the write
// retiring at that edge), then the ALU, condition and pc logic retire it into the
// result register, from which o_rsp is driven; the 16x16 multiply sets
// the critical path. Reset clears pc, zero flag, register valid bits and both stages.
// A stalled result holds the operand stage; state changes only when an item retires.
`timescale 1ns / 1ps
module toy_cpu_execute_stage_core #(
    parameter int P_REG_NUMBER = tcpu_pkg::REG_NUMBER
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcpu_in_if.sink    i_req,
    tcpu_out_if.source o_rsp
);
    import tcpu_pkg::*;

    localparam int REG_AW  = $clog2(P_REG_NUMBER);
    localparam int REG_TOP = P_REG_NUMBER - 1;

    // register file
    logic [DATA_W-1:0]       r_rf [P_REG_NUMBER];
    logic [P_REG_NUMBER-1:0] r_rf_vld;

    // architectural state
    logic [DATA_W-1:0] r_pc;
    logic              r_zero;

    // operand stage
    logic              r_in_vld;
    t_instr            r_in;
    logic [DATA_W-1:0] r_opa;
    logic [DATA_W-1:0] r_opb;

    // result stage
    logic    r_out_vld;
    t_result r_out;

    logic              w_accept;
    logic              w_advance;
    logic [REG_AW-1:0] w_la;
    logic [REG_AW-1:0] w_ra;
    logic [REG_AW-1:0] w_wa;
    logic              w_we;
    logic              w_is_alu;
    logic              w_cond;
    logic [DATA_W-1:0] w_pc_adv;
    logic [DATA_W-1:0] w_alu_b;
    t_alu_rsp          w_alu;
    t_result           n_out;
    logic [DATA_W-1:0] n_pc;
    logic              n_zero;

    assign w_advance   = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || w_advance;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_la = i_req.data.left_reg[REG_AW-1:0];
    assign w_ra = i_req.data.right_reg[REG_AW-1:0];
    assign w_wa = r_in.dest_reg[REG_AW-1:0];

    assign w_is_alu = (r_in.action == ACT_ALU_REG) || (r_in.action == ACT_ALU_IMM);
    assign w_alu_b  = (r_in.action == ACT_ALU_REG) ? r_opb : r_in.immediate;
    assign w_pc_adv = r_pc + DATA_W'(r_in.length);

    // carry never gets set, so carry tests see zero
    always_comb begin
        unique case (r_in.condition)
            CND_ALWAYS:  w_cond = 1'b1;
            CND_NEVER:   w_cond = 1'b0;
            CND_ZERO:    w_cond = r_zero;
            CND_NONZERO: w_cond = !r_zero;
            CND_CARRY:   w_cond = 1'b0;
            CND_NOCARRY: w_cond = 1'b1;
            CND_CARRY_Z: w_cond = r_zero;
            CND_NEITHER: w_cond = !r_zero;
            default:     w_cond = 1'b0;
        endcase
    end

    tcpu_alu u_alu (
        .i_op  (r_in.alu_op),
        .i_a   (r_opa),
        .i_b   (w_alu_b),
        .o_rsp (w_alu)
    );

    assign w_we = w_advance && w_is_alu && !w_alu.bad
                  && (w_wa != '0) && (w_wa != REG_AW'(REG_TOP));

    always_comb begin
        n_pc            = w_pc_adv;
        n_zero          = r_zero;
        n_out.alu_value = '0;
        n_out.taken     = 1'b0;
        n_out.bad_op    = 1'b0;
        priority if (w_is_alu) begin
            n_out.bad_op = w_alu.bad;
            if (!w_alu.bad) begin
                n_out.alu_value = w_alu.value;
                n_zero          = (w_alu.value == '0);
            end
        end else if (r_in.action == ACT_JMP_REG) begin
            n_out.taken = w_cond;
            if (w_cond) n_pc = r_opb;
        end else if (r_in.action == ACT_JMP_IMM) begin
            n_out.taken = w_cond;
            if (w_cond) n_pc = r_in.immediate;
        end else if (r_in.action == ACT_BRANCH) begin
            n_out.taken = w_cond;
            if (w_cond) n_pc = w_pc_adv - r_in.immediate;
        end else begin
            n_out.taken = 1'b0;
        end
        n_out.next_pc  = n_pc;
        n_out.zero_now = n_zero;
    end

    // register file storage
    always_ff @(posedge i_clk) begin
        if (w_we) r_rf[w_wa] <= w_alu.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (w_we) begin
            r_rf_vld[w_wa] <= 1'b1;
        end
    end

    // operand read; bypass the value retiring at this same edge
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_req.data;
            if (w_la == '0)                     r_opa <= '0;
            else if (w_la == REG_AW'(REG_TOP))  r_opa <= '1;
            else if (w_we && w_wa == w_la)      r_opa <= w_alu.value;
            else if (r_rf_vld[w_la])            r_opa <= r_rf[w_la];
            else                                r_opa <= '0;
            if (w_ra == '0)                     r_opb <= '0;
            else if (w_ra == REG_AW'(REG_TOP))  r_opb <= '1;
            else if (w_we && w_wa == w_ra)      r_opb <= w_alu.value;
            else if (r_rf_vld[w_ra])            r_opb <= r_rf[w_ra];
            else                                r_opb <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pc      <= '0;
            r_zero    <= 1'b0;
        end else begin
            if (w_accept)       r_in_vld <= 1'b1;
            else if (w_advance) r_in_vld <= 1'b0;
            if (w_advance) begin
                r_out_vld <= 1'b1;
                r_pc      <= n_pc;
                r_zero    <= n_zero;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) r_out <= n_out;
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    a_bad_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.bad_op) |-> (r_out.alu_value == '0 && !r_out.taken))
        else $error("invalid op produced a value or a jump");

    a_taken_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.taken) |-> (r_out.alu_value == '0))
        else $error("taken jump carries an ALU value");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> ($stable(r_pc) && $stable(r_zero)))
        else $error("state changed without a retiring request");

    a_pc_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_out.next_pc == r_pc && r_out.zero_now == r_zero))
        else $error("result disagrees with retired state");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_rsp.valid && i_req.ready))
        else $error("stages not empty after reset");

endmodule

/* rtl/tcpu_alu.sv */
// Combinational 16-bit ALU of the execute stage.
`timescale 1ns / 1ps
module tcpu_alu (
    input  logic [3:0]                 i_op,
    input  logic [tcpu_pkg::DATA_W-1:0] i_a,
    input  logic [tcpu_pkg::DATA_W-1:0] i_b,
    output tcpu_pkg::t_alu_rsp         o_rsp
);
    import tcpu_pkg::*;

    localparam int SH_W = $clog2(DATA_W);

    logic [DATA_W-1:0] w_prod;
    logic              w_big_shift;

    assign w_prod      = i_a * i_b;
    assign w_big_shift = |i_b[DATA_W-1:SH_W];

    always_comb begin
        o_rsp.bad   = 1'b0;
        o_rsp.value = '0;
        unique case (i_op)
            OP_ADD: o_rsp.value = i_a + i_b;
            OP_SUB: o_rsp.value = i_a - i_b;
            OP_SHL: o_rsp.value = w_big_shift ? '0 : (i_a << i_b[SH_W-1:0]);
            OP_SHR: o_rsp.value = w_big_shift ? '0 : (i_a >> i_b[SH_W-1:0]);
            OP_AND: o_rsp.value = i_a & i_b;
            OP_OR:  o_rsp.value = i_a | i_b;
            OP_XOR: o_rsp.value = i_a ^ i_b;
            OP_MUL: o_rsp.value = w_prod;
            default: o_rsp.bad  = 1'b1;
        endcase
    end

endmodule

/* tb/sv/toy_cpu_execute_stage_core_test.sv */
// Self-checking testbench for the toy processor execute stage.
`timescale 1ns / 1ps
module toy_cpu_execute_stage_core_test;
    import tcpu_pkg::*;

    localparam int RANDOM_ITEMS   = 1325;
    localparam int LONG_HOLD      = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // operation codes outside the defined set
    localparam logic [3:0] OP_FIRST_BAD = 4'd8;
    localparam logic [3:0] OP_LAST_BAD  = 4'd15;
    // instruction kinds past the branch are undefined
    localparam logic [2:0] ACT_UNDEF_LO = 3'd5;
    localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

    typedef struct {
        t_instr  ins;
        bit      known;
        t_result want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcpu_in_if  req_if ();
    tcpu_out_if rsp_if ();

    toy_cpu_execute_stage_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #4 i_clk = ~i_clk;

    // architectural state tracked alongside the block
    logic [DATA_W-1:0] arch_regs [REG_NUMBER];
    logic [DATA_W-1:0] arch_pc;
    logic              arch_zero;

    t_result   pending_results [$];
    t_stim_row stim_table [$];
    int        mismatch_count   = 0;
    int        accepted_results = 0;
    int        stall_cycles     = 0;
    bit        burst_mode       = 1'b0;

    function automatic t_instr mk_instr(input logic [2:0] action, input logic [3:0] op,
                                        input logic [2:0] dst, input logic [2:0] lft,
                                        input logic [2:0] rgt, input logic [DATA_W-1:0] imm,
                                        input logic [2:0] cnd, input logic [2:0] len);
        t_instr ins;
        ins.action    = action;
        ins.alu_op    = op;
        ins.dest_reg  = dst;
        ins.left_reg  = lft;
        ins.right_reg = rgt;
        ins.immediate = imm;
        ins.condition = cnd;
        ins.length    = len;
        return ins;
    endfunction

    function automatic t_result mk_result(input logic [DATA_W-1:0] pc,
                                          input logic [DATA_W-1:0] val,
                                          input logic z, input logic tk, input logic bad);
        return {pc, val, z, tk, bad};
    endfunction

    // Retire one instruction against the tracked state and return its result.
    function automatic t_result retire_instr(input t_instr ins);
        t_result           res;
        logic [DATA_W-1:0] opa;
        logic [DATA_W-1:0] opb;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] pc_next;
        logic              op_ok;
        logic              cond_ok;
        res     = '0;
        val     = '0;
        op_ok   = 1'b1;
        pc_next = arch_pc + DATA_W'(ins.length);
        // carry never sets, so carry terms drop out
        case (ins.condition)
            CND_ALWAYS:  cond_ok = 1'b1;
            CND_NEVER:   cond_ok = 1'b0;
            CND_ZERO:    cond_ok = arch_zero;
            CND_NONZERO: cond_ok = !arch_zero;
            CND_CARRY:   cond_ok = 1'b0;
            CND_NOCARRY: cond_ok = 1'b1;
            CND_CARRY_Z: cond_ok = arch_zero;
            default:     cond_ok = !arch_zero;
        endcase
        case (ins.action)
            ACT_ALU_REG, ACT_ALU_IMM: begin
                opa = arch_regs[ins.left_reg];
                opb = (ins.action == ACT_ALU_REG) ? arch_regs[ins.right_reg] : ins.immediate;
                case (ins.alu_op)
                    OP_ADD:  val = opa + opb;
                    OP_SUB:  val = opa - opb;
                    OP_SHL:  val = (opb >= DATA_W) ? '0 : opa << opb;
                    OP_SHR:  val = (opb >= DATA_W) ? '0 : opa >> opb;
                    OP_AND:  val = opa & opb;
                    OP_OR:   val = opa | opb;
                    OP_XOR:  val = opa ^ opb;
                    OP_MUL:  val = opa * opb;
                    default: op_ok = 1'b0;
                endcase
                if (op_ok) begin
                    arch_zero = (val == '0);
                    if (ins.dest_reg != 3'd0 && ins.dest_reg != 3'd7) begin
                        arch_regs[ins.dest_reg] = val;
                    end
                    res.alu_value = val;
                end else begin
                    res.bad_op = 1'b1;
                end
            end
            ACT_JMP_REG: begin
                if (cond_ok) begin
                    res.taken = 1'b1;
                    pc_next   = arch_regs[ins.right_reg];
                end
            end
            ACT_JMP_IMM: begin
                if (cond_ok) begin
                    res.taken = 1'b1;
                    pc_next   = ins.immediate;
                end
            end
            ACT_BRANCH: begin
                if (cond_ok) begin
                    res.taken = 1'b1;
                    pc_next   = pc_next - ins.immediate;
                end
            end
            default: ;
        endcase
        arch_pc      = pc_next;
        res.next_pc  = pc_next;
        res.zero_now = arch_zero;
        return res;
    endfunction

    function automatic t_instr rand_instr();
        t_instr ins;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) ins.action = ACT_ALU_REG;
        else if (pick < 60) ins.action = ACT_ALU_IMM;
        else if (pick < 70) ins.action = ACT_JMP_REG;
        else if (pick < 80) ins.action = ACT_JMP_IMM;
        else if (pick < 95) ins.action = ACT_BRANCH;
        else ins.action = 3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
        if ($urandom_range(0, 9) == 0) begin
            ins.alu_op = 4'($urandom_range(OP_FIRST_BAD, OP_LAST_BAD));
        end else begin
            ins.alu_op = 4'($urandom_range(OP_ADD, OP_MUL));
        end
        ins.dest_reg  = 3'($urandom_range(0, 7));
        ins.left_reg  = 3'($urandom_range(0, 7));
        ins.right_reg = 3'($urandom_range(0, 7));
        ins.condition = 3'($urandom_range(CND_ALWAYS, CND_NEITHER));
        // favor shift-sized and boundary immediates
        case ($urandom_range(0, 3))
            0: ins.immediate = DATA_W'($urandom_range(0, 20));
            1: begin
                case ($urandom_range(0, 3))
                    0:       ins.immediate = 16'h0000;
                    1:       ins.immediate = 16'hFFFF;
                    2:       ins.immediate = 16'h8000;
                    default: ins.immediate = 16'h7FFF;
                endcase
            end
            default: ins.immediate = DATA_W'($urandom());
        endcase
        if ($urandom_range(0, 7) == 0) begin
            ins.length = 3'($urandom_range(0, 7));
        end else begin
            ins.length = 3'($urandom_range(2, 4));
        end
        return ins;
    endfunction

    task automatic add_row(input t_instr ins, input bit known, input t_result want);
        t_stim_row row;
        row.ins   = ins;
        row.known = known;
        row.want  = want;
        stim_table.push_back(row);
    endtask

    task automatic issue_instr(input t_instr ins, input bit known, input t_result want);
        int      gap;
        t_result predicted;
        gap = burst_mode ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= ins;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = retire_instr(ins);
        pending_results.push_back(known ? want : predicted);
    endtask

    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: result with no pending request, next_pc expected none, got %h",
                     $time, got.next_pc);
            mismatch_count++;
        end else begin
            want = pending_results.pop_front();
            check_field("next_pc", want.next_pc, got.next_pc);
            check_field("alu_value", want.alu_value, got.alu_value);
            check_field("zero_now", DATA_W'(want.zero_now), DATA_W'(got.zero_now));
            check_field("taken", DATA_W'(want.taken), DATA_W'(got.taken));
            check_field("bad_op", DATA_W'(want.bad_op), DATA_W'(got.bad_op));
        end
    endtask

    initial begin : drain_results
        int hold;
        wait (i_rst_n === 1'b1);
        forever begin
            // hold off twice for a long stretch so the stage backs up into the request side
            if (accepted_results == 150 || accepted_results == 700) begin
                hold = LONG_HOLD;
            end else begin
                hold = burst_mode ? 0 : $urandom_range(0, 6);
            end
            if (hold > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
            check_result(rsp_if.data);
            accepted_results++;
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : run_program
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        rsp_if.ready <= 1'b0;
        foreach (arch_regs[k]) arch_regs[k] = '0;
        arch_regs[7] = '1;
        arch_pc      = '0;
        arch_zero    = 1'b0;

        // rows with a typed result follow directly from the reset state
        add_row(mk_instr(ACT_ALU_IMM, OP_ADD, 3'd1, 3'd7, 3'd0, 16'h0001, CND_ALWAYS, 3'd2),
                1'b1, mk_result(16'h0002, 16'h0000, 1'b1, 1'b0, 1'b0));
        add_row(mk_instr(ACT_ALU_IMM, OP_ADD, 3'd2, 3'd7, 3'd0, 16'h0000, CND_ALWAYS, 3'd3),
                1'b1, mk_result(16'h0005, 16'hFFFF, 1'b0, 1'b0, 1'b0));
        add_row(mk_instr(ACT_ALU_REG, OP_MUL, 3'd3, 3'd7, 3'd7, 16'h0000, CND_ALWAYS, 3'd4),
                1'b1, mk_result(16'h0009, 16'h0001, 1'b0, 1'b0, 1'b0));
        add_row(mk_instr(ACT_ALU_IMM, OP_SHL, 3'd4, 3'd7, 3'd0, 16'd16, CND_ALWAYS, 3'd2),
                1'b1, mk_result(16'd11, 16'h0000, 1'b1, 1'b0, 1'b0));
        add_row(mk_instr(ACT_ALU_IMM, OP_SHR, 3'd4, 3'd7, 3'd0, 16'd15, CND_ALWAYS, 3'd2),
                1'b1, mk_result(16'd13, 16'h0001, 1'b0, 1'b0, 1'b0));
        add_row(mk_instr(ACT_ALU_IMM, OP_FIRST_BAD, 3'd5, 3'd7, 3'd0, 16'h0001, CND_ALWAYS,
                         3'd2),
                1'b1, mk_result(16'd15, 16'h0000, 1'b0, 1'b0, 1'b1));
        add_row(mk_instr(ACT_ALU_REG, OP_LAST_BAD, 3'd5, 3'd7, 3'd7, 16'h0000, CND_ALWAYS,
                         3'd3),
                1'b1, mk_result(16'd18, 16'h0000, 1'b0, 1'b0, 1'b1));
        add_row(mk_instr(ACT_ALU_IMM, OP_SUB, 3'd0, 3'd0, 3'd0, 16'h0000, CND_ALWAYS, 3'd2),
                1'b1, mk_result(16'd20, 16'h0000, 1'b1, 1'b0, 1'b0));
        add_row(mk_instr(ACT_ALU_IMM, OP_SUB, 3'd7, 3'd0, 3'd0, 16'h0001, CND_ALWAYS, 3'd2),
                1'b1, mk_result(16'd22, 16'hFFFF, 1'b0, 1'b0, 1'b0));
        add_row(mk_instr(ACT_ALU_REG, OP_AND, 3'd5, 3'd7, 3'd2, 16'h0000, CND_ALWAYS, 3'd2),
                1'b0, '0);
        add_row(mk_instr(ACT_ALU_REG, OP_OR, 3'd6, 3'd3, 3'd4, 16'h0000, CND_ALWAYS, 3'd2),
                1'b0, '0);
        add_row(mk_instr(ACT_ALU_IMM, OP_MUL, 3'd1, 3'd2, 3'd0, 16'hFFFF, CND_ALWAYS, 3'd2),
                1'b0, '0);
        add_row(mk_instr(ACT_ALU_REG, OP_XOR, 3'd6, 3'd6, 3'd6, 16'h0000, CND_ALWAYS, 3'd2),
                1'b0, '0);
        add_row(mk_instr(ACT_JMP_IMM, OP_ADD, 3'd0, 3'd0, 3'd0, 16'h1234, CND_ZERO, 3'd2),
                1'b1, mk_result(16'h1234, 16'h0000, 1'b1, 1'b1, 1'b0));
        add_row(mk_instr(ACT_JMP_IMM, OP_ADD, 3'd0, 3'd0, 3'd0, 16'h0000, CND_NEVER, 3'd4),
                1'b0, '0);
        add_row(mk_instr(ACT_BRANCH, OP_ADD, 3'd0, 3'd0, 3'd0, 16'h8000, CND_ALWAYS, 3'd2),
                1'b0, '0);
        add_row(mk_instr(ACT_BRANCH, OP_ADD, 3'd0, 3'd0, 3'd0, 16'h0005, CND_CARRY, 3'd2),
                1'b0, '0);
        add_row(mk_instr(ACT_JMP_REG, OP_ADD, 3'd0, 3'd0, 3'd2, 16'h0000, CND_NONZERO, 3'd2),
                1'b0, '0);
        add_row(mk_instr(ACT_JMP_REG, OP_ADD, 3'd0, 3'd0, 3'd5, 16'h0000, CND_CARRY_Z, 3'd3),
                1'b0, '0);
        // wraps the pc past the top
        add_row(mk_instr(ACT_ALU_IMM, OP_ADD, 3'd1, 3'd0, 3'd0, 16'h0005, CND_ALWAYS, 3'd4),
                1'b0, '0);
        add_row(mk_instr(ACT_JMP_REG, OP_ADD, 3'd0, 3'd0, 3'd2, 16'h0000, CND_NEITHER, 3'd2),
                1'b0, '0);
        // taken even though the pc lands where it would anyway
        add_row(mk_instr(ACT_BRANCH, OP_ADD, 3'd0, 3'd0, 3'd0, 16'h0000, CND_NOCARRY, 3'd2),
                1'b0, '0);
        add_row(mk_instr(ACT_BRANCH, OP_ADD, 3'd0, 3'd0, 3'd0, 16'h0004, CND_ZERO, 3'd2),
                1'b0, '0);
        add_row(mk_instr(ACT_UNDEF_LO, OP_ADD, 3'd3, 3'd7, 3'd7, 16'hFFFF, CND_ALWAYS, 3'd7),
                1'b0, '0);
        add_row(mk_instr(ACT_UNDEF_HI, OP_MUL, 3'd4, 3'd7, 3'd7, 16'hFFFF, CND_ALWAYS, 3'd0),
                1'b0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[k]) begin
            issue_instr(stim_table[k].ins, stim_table[k].known, stim_table[k].want);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            issue_instr(rand_instr(), 1'b0, '0);
        end
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
